// File: rtl/bem_pkg.sv
`timescale 1ns / 1ps

package bem_pkg;

   // Default size of the button table.
   localparam int DEFAULT_MAX_BUTTONS = 16;

   // Request function codes.
   localparam logic [1:0] FUNC_SAMPLE = 2'd0;
   localparam logic [1:0] FUNC_READ   = 2'd1;
   localparam logic [1:0] FUNC_TICK   = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_BUTTON_COUNT   = 2'd0;
   localparam logic [1:0] CSR_PRESS_WINDOW   = 2'd1;
   localparam logic [1:0] CSR_RELEASE_WINDOW = 2'd2;

   // One row of the button table.
   typedef struct packed {
      logic        held;
      logic        pressed;
      logic        released;
      logic        pending;
      logic [15:0] press_stamp;
      logic [15:0] release_stamp;
      logic [31:0] down_stamp;
   } entry_type;

   // One response transaction.
   typedef struct packed {
      logic        changed;
      logic        found;
      logic        is_down;
      logic        is_pressed;
      logic        is_released;
      logic [31:0] held_ms;
   } result_type;

endpackage

// File: rtl/bem_update.sv
`timescale 1ns / 1ps

module bem_update (
   input  logic [1:0]         item_func,
   input  logic               index_ok,
   input  logic               item_level,
   input  bem_pkg::entry_type cur_entry,
   input  logic [31:0]        now_ms,
   input  logic [15:0]        press_window,
   input  logic [15:0]        release_window,
   output bem_pkg::entry_type nxt_entry,
   output logic               entry_we,
   output bem_pkg::result_type result
);
   import bem_pkg::*;

   logic [15:0] press_elapsed;
   logic [15:0] release_elapsed;
   logic        press_expired;
   logic        release_expired;

   // Elapsed times are taken modulo 2^16; a flag lapses once strictly past its window.
   assign press_elapsed   = now_ms[15:0] - cur_entry.press_stamp;
   assign release_elapsed = now_ms[15:0] - cur_entry.release_stamp;
   assign press_expired   = press_elapsed > press_window;
   assign release_expired = release_elapsed > release_window;

   always_comb begin
      nxt_entry = cur_entry;
      entry_we  = 1'b0;
      result    = '0;
      unique case (item_func)
         FUNC_SAMPLE: begin
            if (index_ok) begin
               entry_we = 1'b1;
               if (item_level) begin
                  if (!cur_entry.held) begin
                     // New press: a fresh stamp cannot be past its window yet.
                     nxt_entry.held          = 1'b1;
                     nxt_entry.down_stamp    = now_ms;
                     nxt_entry.pressed       = 1'b1;
                     nxt_entry.press_stamp   = now_ms[15:0];
                     nxt_entry.released      = 1'b0;
                     nxt_entry.pending       = 1'b0;
                     nxt_entry.release_stamp = '0;
                     result.changed          = 1'b1;
                  end else if (cur_entry.pressed && press_expired) begin
                     nxt_entry.pressed = 1'b0;
                  end
               end else begin
                  if (cur_entry.held && !cur_entry.released) begin
                     nxt_entry.released      = 1'b1;
                     nxt_entry.pending       = 1'b1;
                     nxt_entry.release_stamp = now_ms[15:0];
                     result.changed          = 1'b1;
                  end else if (cur_entry.pending && release_expired) begin
                     nxt_entry.released      = 1'b0;
                     nxt_entry.pending       = 1'b0;
                     nxt_entry.release_stamp = '0;
                  end
                  nxt_entry.held        = 1'b0;
                  nxt_entry.pressed     = 1'b0;
                  nxt_entry.press_stamp = '0;
                  nxt_entry.down_stamp  = '0;
               end
            end
         end
         FUNC_READ: begin
            if (index_ok) begin
               entry_we           = 1'b1;
               result.found       = 1'b1;
               result.is_down     = cur_entry.held;
               result.is_pressed  = cur_entry.pressed;
               result.is_released = cur_entry.released;
               result.held_ms     = cur_entry.held ? (now_ms - cur_entry.down_stamp) : '0;
               nxt_entry.pressed  = 1'b0;
               nxt_entry.released = 1'b0;
            end
         end
         default: begin
            // Ticks and unused codes leave the table alone and answer zeros.
         end
      endcase
   end

endmodule

// File: rtl/button_event_monitor.sv
`timescale 1ns / 1ps

// Button press and release event monitor.
// Request channel (req_*): each transaction is a sample of one button's level, a read of
// one button's state, or a one millisecond tick of the shared time base. Every request
// gives exactly one response transaction (rsp_*), in request order.
// Configuration channel (csr_*): index 0 sets the number of registered buttons, index 1
// the press window and index 2 the release window, both in milliseconds. It is always
// ready; writes belong in idle periods. Writes to other indexes are dropped.
// A request passes through the request register and then the response register, and
// response valid is driven from the response register. The table update for a request
// is done in the cycle that moves it from the request register to the response
// register, so one request per cycle is sustained while the receiver does not stall.
// When the receiver stalls, the response register holds its transaction and the request
// register fills; req_ready drops only once both are full, so nothing is lost.
// Synchronous reset empties both registers, clears the time counter and every button's
// flags, sets the button count to zero and both windows to 500 ms. The stamps are not
// cleared: each is rewritten before the flag that guards its use can be set.
module button_event_monitor #(
   parameter int MAX_BUTTONS = bem_pkg::DEFAULT_MAX_BUTTONS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [3:0]  req_button_index,
   input  logic        req_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_changed,
   output logic        rsp_found,
   output logic        rsp_is_down,
   output logic        rsp_is_pressed,
   output logic        rsp_is_released,
   output logic [31:0] rsp_held_ms,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import bem_pkg::*;

   localparam int IDX_W = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;

   // Configuration registers.
   logic [4:0]  button_count_ff;
   logic [15:0] press_window_ff;
   logic [15:0] release_window_ff;

   // Millisecond time base.
   logic [31:0] now_ms_ff;

   // Button table. The flags are reset; the stamps are payload.
   logic        held_ff     [MAX_BUTTONS];
   logic        pressed_ff  [MAX_BUTTONS];
   logic        released_ff [MAX_BUTTONS];
   logic        pending_ff  [MAX_BUTTONS];
   logic [15:0] press_stamp_ff   [MAX_BUTTONS];
   logic [15:0] release_stamp_ff [MAX_BUTTONS];
   logic [31:0] down_stamp_ff    [MAX_BUTTONS];

   // Request register.
   logic       in_valid_ff;
   logic [1:0] in_func_ff;
   logic [3:0] in_index_ff;
   logic       in_level_ff;

   // Response register.
   logic       out_valid_ff;
   result_type out_result_ff;

   logic             advance;
   logic             index_ok;
   logic [IDX_W-1:0] entry_idx;
   entry_type        cur_entry;
   entry_type        nxt_entry;
   logic             entry_we;
   result_type       result_in;

   // The request in the register moves on whenever the response register is free or
   // is being emptied this cycle; the table is updated in that same cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   // An index is valid below both the configured count and the table size.
   assign index_ok  = (5'(in_index_ff) < button_count_ff) &&
                      (32'(in_index_ff) < 32'(MAX_BUTTONS));
   assign entry_idx = IDX_W'(in_index_ff);

   always_comb begin
      cur_entry.held          = held_ff[entry_idx];
      cur_entry.pressed       = pressed_ff[entry_idx];
      cur_entry.released      = released_ff[entry_idx];
      cur_entry.pending       = pending_ff[entry_idx];
      cur_entry.press_stamp   = press_stamp_ff[entry_idx];
      cur_entry.release_stamp = release_stamp_ff[entry_idx];
      cur_entry.down_stamp    = down_stamp_ff[entry_idx];
   end

   bem_update u_update (
      .item_func      (in_func_ff),
      .index_ok       (index_ok),
      .item_level     (in_level_ff),
      .cur_entry      (cur_entry),
      .now_ms         (now_ms_ff),
      .press_window   (press_window_ff),
      .release_window (release_window_ff),
      .nxt_entry      (nxt_entry),
      .entry_we       (entry_we),
      .result         (result_in)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         button_count_ff   <= '0;
         press_window_ff   <= 16'd500;
         release_window_ff <= 16'd500;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BUTTON_COUNT:   button_count_ff   <= csr_data[4:0];
            CSR_PRESS_WINDOW:   press_window_ff   <= csr_data;
            CSR_RELEASE_WINDOW: release_window_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Time base advances on tick requests as they are processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ms_ff <= '0;
      end else if (advance && (in_func_ff == FUNC_TICK)) begin
         now_ms_ff <= now_ms_ff + 32'd1;
      end
   end

   // Table flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_BUTTONS; i++) begin
            held_ff[i]     <= 1'b0;
            pressed_ff[i]  <= 1'b0;
            released_ff[i] <= 1'b0;
            pending_ff[i]  <= 1'b0;
         end
      end else if (advance && entry_we) begin
         held_ff[entry_idx]     <= nxt_entry.held;
         pressed_ff[entry_idx]  <= nxt_entry.pressed;
         released_ff[entry_idx] <= nxt_entry.released;
         pending_ff[entry_idx]  <= nxt_entry.pending;
      end
   end

   // Table stamps.
   always_ff @(posedge clock) begin
      if (advance && entry_we) begin
         press_stamp_ff[entry_idx]   <= nxt_entry.press_stamp;
         release_stamp_ff[entry_idx] <= nxt_entry.release_stamp;
         down_stamp_ff[entry_idx]    <= nxt_entry.down_stamp;
      end
   end

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_func_ff  <= req_func;
         in_index_ff <= req_button_index;
         in_level_ff <= req_level;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= result_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_changed     = out_result_ff.changed;
   assign rsp_found       = out_result_ff.found;
   assign rsp_is_down     = out_result_ff.is_down;
   assign rsp_is_pressed  = out_result_ff.is_pressed;
   assign rsp_is_released = out_result_ff.is_released;
   assign rsp_held_ms     = out_result_ff.held_ms;

endmodule
